// ===== rtl/bdl_pkg.sv =====
// shared types and constants for the bounded damerau-levenshtein block
// word structs, action codes, register indexes and sizes; no dependencies
package bdl_pkg;

  localparam int unsigned MAX_LEN   = 255;
  localparam int unsigned ADDR_W    = 8;
  localparam int unsigned MEM_DEPTH = 1 << ADDR_W;
  localparam int unsigned DIST_W    = 13;
  localparam int unsigned COST_W    = 4;
  localparam int unsigned ROWS      = 3;
  localparam int unsigned PADDR_W   = 5;

  localparam logic [1:0] ACT_FIRST   = 2'd0;
  localparam logic [1:0] ACT_SECOND  = 2'd1;
  localparam logic [1:0] ACT_COMPUTE = 2'd2;

  localparam logic [2:0] REG_LIMIT = 3'd0;
  localparam logic [2:0] REG_SWAP  = 3'd1;
  localparam logic [2:0] REG_SUB   = 3'd2;
  localparam logic [2:0] REG_INS   = 3'd3;
  localparam logic [2:0] REG_DEL   = 3'd4;

  localparam logic [7:0]        LIMIT_RESET = 8'd10;
  localparam logic [COST_W-1:0] COST_RESET  = 4'd1;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] char_byte;
  } in_word_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              error_flag;
  } out_word_t;

endpackage

// ===== rtl/bounded_damerau_levenshtein.sv =====
// bounded optimal-string-alignment distance engine, top level
// uses bdl_pkg for word types, action codes and register indexes
//
// usage: words on the in_ channel (valid/ready) append a byte to the first
// or second string, or request a compute. each string keeps at most
// the configured limit of bytes, extra appends are dropped. a compute returns one word
// on the out_ channel with the weighted distance and an error flag for a
// limit outside 1..254; both strings are cleared afterwards. action 3 is
// taken and ignored.
// a compute with clipped lengths n1, n2 (both nonzero) fills row zero, then
// runs a row setup, a row prime and the cells of each row, one dp cell
// evaluated per cycle in the cell state in a single add/compare unit reading
// three row memories; trivial computes go straight to the done state.
// in_ready is high only while the sequencer is idle, so no new word is
// taken during a compute. a finished result moves to the output register
// and the sequencer goes idle again; if the receiver stalls, appends are
// still taken, and the next result waits in the done state with in_ready
// low until the output register is freed.
// reset (rst_n low, synchronous) clears counts, the sequencer and the
// output valid; the apb registers return to limit 10 and costs 1.
module bounded_damerau_levenshtein (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  bdl_pkg::in_word_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output bdl_pkg::out_word_t               out_data,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bdl_pkg::PADDR_W-1:0]      paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_INIT      = 6'b000010,
    ST_ROW_SETUP = 6'b000100,
    ST_ROW_PRIME = 6'b001000,
    ST_CELL      = 6'b010000,
    ST_DONE      = 6'b100000
  } state_t;

  localparam int unsigned AW = bdl_pkg::ADDR_W;
  localparam int unsigned DW = bdl_pkg::DIST_W;
  localparam int unsigned CW = bdl_pkg::COST_W;

  state_t state_r, state_nxt;

  // configuration
  logic [7:0]    limit_r;
  logic [CW-1:0] swap_r, sub_r, ins_r, del_r;

  // string storage
  logic [7:0] first_mem  [bdl_pkg::MEM_DEPTH];
  logic [7:0] second_mem [bdl_pkg::MEM_DEPTH];
  logic [7:0] first_rd_r, second_rd_r;
  logic [7:0] first_count_r, first_count_nxt;
  logic [7:0] second_count_r, second_count_nxt;

  // dp rows, roles rotate between the three memories
  logic [DW-1:0] row_mem [bdl_pkg::ROWS][bdl_pkg::MEM_DEPTH];
  logic [DW-1:0] row_rd_r [bdl_pkg::ROWS];
  logic [1:0]    before_idx_r, last_idx_r, cur_idx_r;
  logic [1:0]    before_idx_nxt, last_idx_nxt, cur_idx_nxt;

  // sequencer datapath
  logic [AW-1:0] n1_r, n1_nxt, n2_r, n2_nxt;
  logic [AW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [DW-1:0] ins_acc_r, ins_acc_nxt, del_acc_r, del_acc_nxt;
  logic [DW-1:0] lastj_r, lastj_nxt, cur_prev_r, cur_prev_nxt;
  logic [7:0]    a_cur_r, a_cur_nxt, a_prev_r, a_prev_nxt, b_prev_r, b_prev_nxt;
  logic [DW-1:0] res_dist_r, res_dist_nxt;
  logic          res_err_r, res_err_nxt;

  logic               out_valid_r, out_valid_nxt;
  bdl_pkg::out_word_t out_data_r, out_data_nxt;

  logic          in_fire, cfg_write;
  logic [AW-1:0] clip1, clip2;
  logic [AW-1:0] last_raddr, before_raddr, second_raddr, row_waddr;
  logic [DW-1:0] row_wdata;
  logic          row_write;
  logic [DW-1:0] last_rd, before_rd;

  // cell evaluation unit
  logic [DW:0]   sum_sub, cand_t, cand_d, cand_i, v1, v2, v3;
  logic          trans_ok;
  logic [DW-1:0] v_cell;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // apb register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= bdl_pkg::LIMIT_RESET;
      swap_r  <= bdl_pkg::COST_RESET;
      sub_r   <= bdl_pkg::COST_RESET;
      ins_r   <= bdl_pkg::COST_RESET;
      del_r   <= bdl_pkg::COST_RESET;
    end else if (cfg_write) begin
      unique case (paddr[4:2])
        bdl_pkg::REG_LIMIT: limit_r <= pwdata[7:0];
        bdl_pkg::REG_SWAP:  swap_r  <= pwdata[CW-1:0];
        bdl_pkg::REG_SUB:   sub_r   <= pwdata[CW-1:0];
        bdl_pkg::REG_INS:   ins_r   <= pwdata[CW-1:0];
        bdl_pkg::REG_DEL:   del_r   <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      bdl_pkg::REG_LIMIT: prdata = {24'd0, limit_r};
      bdl_pkg::REG_SWAP:  prdata = {28'd0, swap_r};
      bdl_pkg::REG_SUB:   prdata = {28'd0, sub_r};
      bdl_pkg::REG_INS:   prdata = {28'd0, ins_r};
      bdl_pkg::REG_DEL:   prdata = {28'd0, del_r};
      default:            prdata = 32'd0;
    endcase
  end

  assign clip1 = (first_count_r < limit_r) ? first_count_r : limit_r;
  assign clip2 = (second_count_r < limit_r) ? second_count_r : limit_r;

  // read addresses follow the cell stream one step ahead
  always_comb begin
    last_raddr   = AW'(j_r + AW'(2));
    before_raddr = j_r;
    second_raddr = AW'(j_r + AW'(1));
    if (state_r == ST_ROW_SETUP) begin
      last_raddr = '0;
    end
    if (state_r == ST_ROW_PRIME) begin
      last_raddr   = AW'(1);
      second_raddr = '0;
    end
  end

  always_comb begin
    row_write = 1'b0;
    row_waddr = AW'(j_r + AW'(1));
    row_wdata = v_cell;
    if (state_r == ST_INIT) begin
      row_write = 1'b1;
      row_waddr = j_r;
      row_wdata = ins_acc_r;
    end else if (state_r == ST_ROW_PRIME) begin
      row_write = 1'b1;
      row_waddr = '0;
      row_wdata = del_acc_r;
    end else if (state_r == ST_CELL) begin
      row_write = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_data.action == bdl_pkg::ACT_FIRST &&
        first_count_r < limit_r && first_count_r < 8'(bdl_pkg::MAX_LEN)) begin
      first_mem[first_count_r] <= in_data.char_byte;
    end
    if (in_fire && in_data.action == bdl_pkg::ACT_SECOND &&
        second_count_r < limit_r && second_count_r < 8'(bdl_pkg::MAX_LEN)) begin
      second_mem[second_count_r] <= in_data.char_byte;
    end
    first_rd_r  <= first_mem[i_r];
    second_rd_r <= second_mem[second_raddr];
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < bdl_pkg::ROWS; k++) begin
      if (row_write && ((state_r == ST_INIT) ? (last_idx_r == 2'(k))
                                             : (cur_idx_r == 2'(k)))) begin
        row_mem[k][row_waddr] <= row_wdata;
      end
      row_rd_r[k] <= row_mem[k][(last_idx_r == 2'(k)) ? last_raddr : before_raddr];
    end
  end

  assign last_rd   = row_rd_r[last_idx_r];
  assign before_rd = row_rd_r[before_idx_r];

  // one dp cell: substitution, transposition, deletion, insertion
  always_comb begin
    sum_sub  = {1'b0, lastj_r} + ((a_cur_r != second_rd_r) ? (DW+1)'(sub_r) : '0);
    cand_t   = {1'b0, before_rd} + (DW+1)'(swap_r);
    cand_d   = {1'b0, last_rd} + (DW+1)'(del_r);
    cand_i   = {1'b0, cur_prev_r} + (DW+1)'(ins_r);
    trans_ok = (i_r != '0) && (j_r != '0) && (a_prev_r == second_rd_r) &&
               (a_cur_r == b_prev_r);
    v1 = (trans_ok && sum_sub > cand_t) ? cand_t : sum_sub;
    v2 = (v1 > cand_d) ? cand_d : v1;
    v3 = (v2 > cand_i) ? cand_i : v2;
    v_cell = v3[DW-1:0];
  end

  always_comb begin
    state_nxt        = state_r;
    first_count_nxt  = first_count_r;
    second_count_nxt = second_count_r;
    n1_nxt           = n1_r;
    n2_nxt           = n2_r;
    i_nxt            = i_r;
    j_nxt            = j_r;
    ins_acc_nxt      = ins_acc_r;
    del_acc_nxt      = del_acc_r;
    lastj_nxt        = lastj_r;
    cur_prev_nxt     = cur_prev_r;
    a_cur_nxt        = a_cur_r;
    a_prev_nxt       = a_prev_r;
    b_prev_nxt       = b_prev_r;
    res_dist_nxt     = res_dist_r;
    res_err_nxt      = res_err_r;
    before_idx_nxt   = before_idx_r;
    last_idx_nxt     = last_idx_r;
    cur_idx_nxt      = cur_idx_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_data_nxt     = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_data.action)
            bdl_pkg::ACT_FIRST: begin
              if (first_count_r < limit_r && first_count_r < 8'(bdl_pkg::MAX_LEN)) begin
                first_count_nxt = first_count_r + 8'd1;
              end
            end
            bdl_pkg::ACT_SECOND: begin
              if (second_count_r < limit_r && second_count_r < 8'(bdl_pkg::MAX_LEN)) begin
                second_count_nxt = second_count_r + 8'd1;
              end
            end
            bdl_pkg::ACT_COMPUTE: begin
              first_count_nxt  = '0;
              second_count_nxt = '0;
              n1_nxt           = clip1;
              n2_nxt           = clip2;
              res_err_nxt      = 1'b0;
              res_dist_nxt     = '0;
              i_nxt            = '0;
              j_nxt            = '0;
              ins_acc_nxt      = '0;
              del_acc_nxt      = DW'(del_r);
              before_idx_nxt   = 2'd0;
              last_idx_nxt     = 2'd1;
              cur_idx_nxt      = 2'd2;
              state_nxt        = ST_DONE;
              if (limit_r == 8'd0 || limit_r == 8'hFF) begin
                res_err_nxt = 1'b1;
              end else if (clip1 == '0) begin
                res_dist_nxt = DW'(clip2);
              end else if (clip2 == '0) begin
                res_dist_nxt = DW'(clip1);
              end else begin
                state_nxt = ST_INIT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_INIT: begin
        // row zero: j * insertion cost for j = 0..n2
        ins_acc_nxt = ins_acc_r + DW'(ins_r);
        j_nxt       = j_r + AW'(1);
        if (j_r == n2_r) begin
          state_nxt = ST_ROW_SETUP;
        end
      end
      ST_ROW_SETUP: begin
        state_nxt = ST_ROW_PRIME;
      end
      ST_ROW_PRIME: begin
        lastj_nxt    = last_rd;
        a_prev_nxt   = a_cur_r;
        a_cur_nxt    = first_rd_r;
        cur_prev_nxt = del_acc_r;
        j_nxt        = '0;
        state_nxt    = ST_CELL;
      end
      ST_CELL: begin
        cur_prev_nxt = v_cell;
        lastj_nxt    = last_rd;
        b_prev_nxt   = second_rd_r;
        j_nxt        = j_r + AW'(1);
        if (j_r == n2_r - AW'(1)) begin
          before_idx_nxt = last_idx_r;
          last_idx_nxt   = cur_idx_r;
          cur_idx_nxt    = before_idx_r;
          i_nxt          = i_r + AW'(1);
          del_acc_nxt    = del_acc_r + DW'(del_r);
          if (i_r == n1_r - AW'(1)) begin
            res_dist_nxt = v_cell;
            state_nxt    = ST_DONE;
          end else begin
            state_nxt = ST_ROW_SETUP;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.distance   = res_dist_r;
          out_data_nxt.error_flag = res_err_r;
          state_nxt               = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      first_count_r  <= '0;
      second_count_r <= '0;
      out_valid_r    <= 1'b0;
      before_idx_r   <= 2'd0;
      last_idx_r     <= 2'd1;
      cur_idx_r      <= 2'd2;
    end else begin
      state_r        <= state_nxt;
      first_count_r  <= first_count_nxt;
      second_count_r <= second_count_nxt;
      out_valid_r    <= out_valid_nxt;
      before_idx_r   <= before_idx_nxt;
      last_idx_r     <= last_idx_nxt;
      cur_idx_r      <= cur_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n1_r       <= n1_nxt;
    n2_r       <= n2_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    ins_acc_r  <= ins_acc_nxt;
    del_acc_r  <= del_acc_nxt;
    lastj_r    <= lastj_nxt;
    cur_prev_r <= cur_prev_nxt;
    a_cur_r    <= a_cur_nxt;
    a_prev_r   <= a_prev_nxt;
    b_prev_r   <= b_prev_nxt;
    res_dist_r <= res_dist_nxt;
    res_err_r  <= res_err_nxt;
    out_data_r <= out_data_nxt;
  end

  // a new result word only appears out of the done state
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result word raised outside done state");

  // an error word always carries a zero distance
  a_error_zero_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.error_flag |-> out_data_r.distance == '0)
    else $error("error word with nonzero distance");

  // the three dp row roles never share a memory
  a_roles_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    before_idx_r != last_idx_r && last_idx_r != cur_idx_r && cur_idx_r != before_idx_r)
    else $error("dp row roles overlap");

  // the cell column never runs past the second string
  a_cell_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CELL |-> j_r < n2_r && i_r < n1_r)
    else $error("cell index out of range");

endmodule

// ===== tb/bounded_damerau_levenshtein_test.sv =====
// self-checking testbench for bounded_damerau_levenshtein: loads string pairs, requests
// distances and checks each result word against an in-bench edit distance tracker
// depends on bdl_pkg and the bounded_damerau_levenshtein rtl only
module bounded_damerau_levenshtein_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  ACT_UNUSED    = 2'd3;
  localparam int unsigned LIMIT_INVALID = 255;
  localparam int unsigned DIST_SAT      = (1 << bdl_pkg::DIST_W) - 1;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned END_CYCLES    = 64;
  localparam int unsigned HOLD_CYCLES   = 600;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_WORDS   = 45;

  typedef enum int unsigned {RX_OPEN, RX_COIN, RX_TIGHT} rx_mode_t;
  typedef enum int unsigned {EDIT_SWAP, EDIT_REPLACE, EDIT_INSERT, EDIT_DROP} edit_kind_t;

  logic                        clk;
  logic                        rst_n     = 1'b0;
  logic                        in_valid  = 1'b0;
  logic                        in_ready;
  bdl_pkg::in_word_t           in_data   = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  bdl_pkg::out_word_t          out_data;
  logic                        psel      = 1'b0;
  logic                        penable   = 1'b0;
  logic                        pwrite    = 1'b0;
  logic [bdl_pkg::PADDR_W-1:0] paddr     = '0;
  logic [31:0]                 pwdata    = '0;
  logic [31:0]                 prdata;
  logic                        pready;

  bounded_damerau_levenshtein i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // tracked copy of the block's registers and strings
  int unsigned lim_reg = 32'(bdl_pkg::LIMIT_RESET);
  int unsigned swap_w  = 32'(bdl_pkg::COST_RESET);
  int unsigned sub_w   = 32'(bdl_pkg::COST_RESET);
  int unsigned ins_w   = 32'(bdl_pkg::COST_RESET);
  int unsigned del_w   = 32'(bdl_pkg::COST_RESET);
  logic [7:0]  str_a [0:bdl_pkg::MAX_LEN-1];
  logic [7:0]  str_b [0:bdl_pkg::MAX_LEN-1];
  int unsigned len_a = 0;
  int unsigned len_b = 0;
  int unsigned dp [0:2][0:bdl_pkg::MAX_LEN+1];

  bdl_pkg::in_word_t  word_backlog [$];
  bdl_pkg::out_word_t expected_distances [$];
  int unsigned words_unaccepted = 0;
  int unsigned words_accepted   = 0;
  int unsigned results_checked  = 0;
  int unsigned config_writes    = 0;
  int unsigned failures         = 0;
  int unsigned phase_words      = 0;
  int unsigned cycle_count      = 0;

  int unsigned        burst_left = 0;
  int unsigned        gap_left   = 0;
  logic               next_valid;
  int unsigned        stretch_left = 0;
  int unsigned        hold_left    = 0;
  rx_mode_t           rx_mode      = RX_OPEN;
  logic               hold_request = 1'b0;
  logic               hold_done    = 1'b0;
  bdl_pkg::out_word_t oldest_result;

  int unsigned phase_lim  [PHASES] = '{3, 254, 1, 8, 0, 16, 255, 6};
  int unsigned phase_swap [PHASES] = '{1, 2, 15, 0, 5, 15, 1, 0};
  int unsigned phase_sub  [PHASES] = '{1, 3, 15, 0, 5, 0, 2, 0};
  int unsigned phase_ins  [PHASES] = '{1, 1, 15, 0, 5, 7, 3, 0};
  int unsigned phase_del  [PHASES] = '{1, 1, 15, 0, 5, 15, 4, 0};

  // restricted damerau-levenshtein over the clipped strings, three rolling rows
  function automatic int unsigned string_distance(int unsigned n1, int unsigned n2);
    int unsigned older, prior, fresh, spare, best, i, j;
    older = 0;
    prior = 1;
    fresh = 2;
    for (j = 0; j <= n2; j++) dp[prior][j] = j * ins_w;
    for (i = 0; i < n1; i++) begin
      dp[fresh][0] = (i + 1) * del_w;
      for (j = 0; j < n2; j++) begin
        best = dp[prior][j] + ((str_a[i] != str_b[j]) ? sub_w : 0);
        if (i > 0 && j > 0 && str_a[i-1] == str_b[j] && str_a[i] == str_b[j-1] &&
            best > dp[older][j-1] + swap_w)
          best = dp[older][j-1] + swap_w;
        if (best > dp[prior][j+1] + del_w) best = dp[prior][j+1] + del_w;
        if (best > dp[fresh][j] + ins_w) best = dp[fresh][j] + ins_w;
        dp[fresh][j+1] = best;
      end
      spare = older;
      older = prior;
      prior = fresh;
      fresh = spare;
    end
    return dp[prior][n2];
  endfunction

  function automatic void absorb_word(bdl_pkg::in_word_t w);
    bdl_pkg::out_word_t res;
    int unsigned        n1, n2, d;
    case (w.action)
      bdl_pkg::ACT_FIRST: begin
        if (len_a < lim_reg && len_a < bdl_pkg::MAX_LEN) begin
          str_a[len_a] = w.char_byte;
          len_a++;
        end
      end
      bdl_pkg::ACT_SECOND: begin
        if (len_b < lim_reg && len_b < bdl_pkg::MAX_LEN) begin
          str_b[len_b] = w.char_byte;
          len_b++;
        end
      end
      bdl_pkg::ACT_COMPUTE: begin
        res = '0;
        if (lim_reg == 0 || lim_reg >= LIMIT_INVALID) begin
          res.error_flag = 1'b1;
        end else begin
          // limit may have been lowered after loading
          n1 = (len_a < lim_reg) ? len_a : lim_reg;
          n2 = (len_b < lim_reg) ? len_b : lim_reg;
          if (n1 == 0) d = n2;
          else if (n2 == 0) d = n1;
          else d = string_distance(n1, n2);
          if (d > DIST_SAT) d = DIST_SAT;
          res.distance = d[bdl_pkg::DIST_W-1:0];
        end
        expected_distances.push_back(res);
        len_a = 0;
        len_b = 0;
      end
      default: ;
    endcase
  endfunction

  // sender: bursts of words separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      next_valid = in_valid;
      if (in_valid && in_ready) begin
        absorb_word(in_data);
        words_accepted++;
        words_unaccepted--;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (word_backlog.size() > 0) begin
          in_data <= word_backlog.pop_front();
          next_valid = 1'b1;
          if (burst_left == 0) burst_left = $urandom_range(1, 24);
          burst_left--;
          if (burst_left == 0)
            gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 5);
        end
      end
      in_valid <= next_valid;
    end
  end

  // receiver: stretches of open, coin-flip or mostly stalled ready, plus one long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stretch_left = 0;
      hold_left = 0;
    end else begin
      if (hold_request && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (stretch_left == 0) begin
          stretch_left = $urandom_range(1, 40);
          rx_mode = rx_mode_t'($urandom_range(0, 2));
        end
        stretch_left--;
        case (rx_mode)
          RX_OPEN: out_ready <= 1'b1;
          RX_COIN: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_checked++;
      if (expected_distances.size() == 0) begin
        $error("unexpected result word: distance %0d error_flag %0d",
               out_data.distance, out_data.error_flag);
        failures++;
      end else begin
        oldest_result = expected_distances.pop_front();
        if (out_data.distance !== oldest_result.distance) begin
          $error("distance: expected %0d, got %0d", oldest_result.distance, out_data.distance);
          failures++;
        end
        if (out_data.error_flag !== oldest_result.error_flag) begin
          $error("error_flag: expected %0d, got %0d",
                 oldest_result.error_flag, out_data.error_flag);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timed out after %0d cycles, %0d results still owed",
               cycle_count, expected_distances.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send(logic [1:0] act, logic [7:0] ch);
    bdl_pkg::in_word_t w;
    w.action = act;
    w.char_byte = ch;
    word_backlog.push_back(w);
    words_unaccepted++;
    phase_words++;
  endtask

  task automatic send_text(logic [1:0] act, string s);
    for (int k = 0; k < s.len(); k++) send(act, s[k]);
  endtask

  task automatic wait_drained();
    while (words_unaccepted != 0 || expected_distances.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // setup cycle, then access cycle; the register takes the value at the following edge
  task automatic write_reg(logic [2:0] idx, int unsigned value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      bdl_pkg::REG_LIMIT: lim_reg = value & 8'hFF;
      bdl_pkg::REG_SWAP:  swap_w  = value & 4'hF;
      bdl_pkg::REG_SUB:   sub_w   = value & 4'hF;
      bdl_pkg::REG_INS:   ins_w   = value & 4'hF;
      bdl_pkg::REG_DEL:   del_w   = value & 4'hF;
      default: ;
    endcase
    config_writes++;
  endtask

  task automatic apply_setting(int unsigned lim, int unsigned sw, int unsigned sb,
                               int unsigned ic, int unsigned dc);
    write_reg(bdl_pkg::REG_LIMIT, lim);
    write_reg(bdl_pkg::REG_SWAP, sw);
    write_reg(bdl_pkg::REG_SUB, sb);
    write_reg(bdl_pkg::REG_INS, ic);
    write_reg(bdl_pkg::REG_DEL, dc);
  endtask

  function automatic logic [7:0] pick_char(bit narrow);
    return narrow ? 8'(8'h61 + $urandom_range(0, 3)) : 8'($urandom_range(0, 255));
  endfunction

  // one string pair, often the second an edited copy of the first, then usually a compute
  task automatic queue_pair(int unsigned lim);
    logic [7:0]  a [$];
    logic [7:0]  b [$];
    int unsigned cap, na, nb, pos;
    bit          narrow;
    logic [7:0]  t;
    cap = (lim + 2 > 40) ? 40 : lim + 2;
    narrow = ($urandom_range(0, 9) < 6);
    na = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, cap);
    for (int k = 0; k < na; k++) a.push_back(pick_char(narrow));
    if ($urandom_range(0, 1)) begin
      b = a;
      repeat ($urandom_range(0, 3)) begin
        case (edit_kind_t'($urandom_range(0, 3)))
          EDIT_SWAP: begin
            if (b.size() > 1) begin
              pos = $urandom_range(0, b.size() - 2);
              t = b[pos];
              b[pos] = b[pos+1];
              b[pos+1] = t;
            end
          end
          EDIT_REPLACE: begin
            if (b.size() > 0) b[$urandom_range(0, b.size() - 1)] = pick_char(narrow);
          end
          EDIT_INSERT: begin
            if (b.size() > 0) b.insert($urandom_range(0, b.size() - 1), pick_char(narrow));
            else b.push_back(pick_char(narrow));
          end
          default: begin
            if (b.size() > 0) b.delete($urandom_range(0, b.size() - 1));
          end
        endcase
      end
    end else begin
      nb = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, cap);
      for (int k = 0; k < nb; k++) b.push_back(pick_char(narrow));
    end
    while (b.size() > cap) void'(b.pop_back());
    while (a.size() > 0 || b.size() > 0) begin
      if (a.size() > 0 && (b.size() == 0 || $urandom_range(0, 1)))
        send(bdl_pkg::ACT_FIRST, a.pop_front());
      else
        send(bdl_pkg::ACT_SECOND, b.pop_front());
      if ($urandom_range(0, 19) == 0) send(ACT_UNUSED, 8'($urandom_range(0, 255)));
    end
    // now and then the compute is left out, so the next pair piles onto these strings
    if ($urandom_range(0, 19) != 0) begin
      send(bdl_pkg::ACT_COMPUTE, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty pair, a transposition, extreme bytes and an unused action
    send(bdl_pkg::ACT_COMPUTE, 8'h00);
    send_text(bdl_pkg::ACT_FIRST, "ab");
    send_text(bdl_pkg::ACT_SECOND, "ba");
    send(bdl_pkg::ACT_COMPUTE, 8'hFF);
    send(bdl_pkg::ACT_FIRST, 8'h00);
    send(bdl_pkg::ACT_FIRST, 8'hFF);
    send(bdl_pkg::ACT_SECOND, 8'hFF);
    send(ACT_UNUSED, 8'h5A);
    send(bdl_pkg::ACT_COMPUTE, 8'hA5);
    wait_drained();

    // full string and an empty partner, the length is returned unweighted
    apply_setting(2, 15, 15, 15, 7);
    send_text(bdl_pkg::ACT_FIRST, "xyz");
    send(bdl_pkg::ACT_COMPUTE, 8'h00);
    wait_drained();

    // limit lowered after the strings were loaded
    apply_setting(10, 1, 1, 1, 1);
    send_text(bdl_pkg::ACT_FIRST, "abcd");
    send_text(bdl_pkg::ACT_SECOND, "abd");
    wait_drained();
    write_reg(bdl_pkg::REG_LIMIT, 3);
    send(bdl_pkg::ACT_COMPUTE, 8'h00);
    wait_drained();

    // both invalid limits
    write_reg(bdl_pkg::REG_LIMIT, 0);
    send(bdl_pkg::ACT_FIRST, 8'h71);
    send(bdl_pkg::ACT_COMPUTE, 8'h00);
    wait_drained();
    write_reg(bdl_pkg::REG_LIMIT, LIMIT_INVALID);
    send(bdl_pkg::ACT_COMPUTE, 8'h00);

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      if (p == PHASES - 1) begin
        phase_swap[p] = $urandom_range(0, 15);
        phase_sub[p]  = $urandom_range(0, 15);
        phase_ins[p]  = $urandom_range(0, 15);
        phase_del[p]  = $urandom_range(0, 15);
      end
      apply_setting(phase_lim[p], phase_swap[p], phase_sub[p], phase_ins[p], phase_del[p]);
      if (p == 0) begin
        @(posedge clk);
        hold_request <= 1'b1;
      end
      phase_words = 0;
      while (phase_words < PHASE_WORDS) queue_pair(phase_lim[p]);
    end

    wait_drained();
    repeat (END_CYCLES) @(posedge clk);
    $display("%0d words accepted, %0d result words checked, %0d register writes",
             words_accepted, results_checked, config_writes);
    $display("limits 0 to 255 and costs 0 to 15 visited, long output hold %0s",
             hold_done ? "done" : "missed");
    if (failures == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
